FILE: rtl/core/signed_word_hash_32_assert.svh
// Assertion macros for the signed word hash block.
// No dependencies; included by the modules that carry assertions.
`ifndef SIGNED_WORD_HASH_32_ASSERT_SVH
`define SIGNED_WORD_HASH_32_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define SWH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define SWH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/swh_pkg.sv
// Package for the signed word hash block: widths, byte-count codes, mixing functions.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package swh_pkg;

    localparam int WORD_W   = 32;
    localparam int NBYTES_W = 3;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [NBYTES_W-1:0] nbytes_t;

    // byte counts of a short tail
    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_ONE  = 2'd1;
    localparam logic [1:0] TAIL_TWO  = 2'd2;
    localparam logic [1:0] TAIL_THREE = 2'd3;

    localparam nbytes_t NBYTES_FULL = nbytes_t'(4);

    function automatic word_t asr(input word_t x, input int unsigned n);
        return word_t'($signed(x) >>> n);
    endfunction

    function automatic word_t sext16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic word_t sext8(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

    function automatic word_t mix_word(input word_t c_in, input word_t w);
        word_t c;
        word_t hi;
        c  = c_in + sext16(w[15:0]);
        hi = sext16(w[31:16]) ^ (c << 5);
        hi = hi << 11;
        c  = c ^ hi;
        c  = c + asr(c, 11);
        return c;
    endfunction

    function automatic word_t mix_tail(input word_t c_in, input word_t w, input logic [1:0] n);
        word_t c;
        word_t t;
        c = c_in;
        t = '0;
        case (n)
            TAIL_THREE:
            begin
                c = c + sext16(w[15:0]);
                t = (sext8(w[23:16]) << 2) ^ c;
                c = c ^ (t << 16);
                c = c + asr(c, 11);
            end
            TAIL_TWO:
            begin
                c = c + sext16(w[15:0]);
                c = c ^ (c << 11);
                c = c + asr(c, 17);
            end
            TAIL_ONE:
            begin
                c = c + sext8(w[7:0]);
                c = c ^ (c << 10);
                c = c + asr(c, 1);
            end
            default:
            begin
                c = c_in;
            end
        endcase
        return c;
    endfunction

    function automatic word_t avalanche(input word_t c_in);
        word_t c;
        c = c_in ^ (c_in << 3);
        c = c + asr(c, 5);
        c = c ^ (c << 4);
        c = c + asr(c, 17);
        c = c ^ (c << 25);
        c = c + asr(c, 6);
        return c;
    endfunction

endpackage

FILE: rtl/core/swh_if.sv
// Valid/ready channel interfaces for the signed word hash block.
// Depends on swh_pkg for field widths.
`timescale 1ns / 1ps

interface swh_in_if;
    logic                 valid;
    logic                 ready;
    logic                 first;
    logic                 last;
    swh_pkg::word_t       data_word;
    swh_pkg::nbytes_t     valid_bytes;
    swh_pkg::word_t       total_length;

    modport source (output valid, first, last, data_word, valid_bytes, total_length,
                    input ready);
    modport sink   (input valid, first, last, data_word, valid_bytes, total_length,
                    output ready);
endinterface

interface swh_out_if;
    logic           valid;
    logic           ready;
    swh_pkg::word_t hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

FILE: rtl/core/signed_word_hash_32.sv
// Signed word hash, top level: input register, mixing stage, result register.
// Depends on swh_pkg, swh_if.sv and signed_word_hash_32_assert.svh.
//
// Usage:
//   msg    : valid/ready sink, one message word per handshake (first, last,
//            data_word, valid_bytes, total_length). total_length is taken on
//            the word flagged first; only the last word may be short.
//   result : valid/ready source, one hash_value per word flagged last.
// Path: a last word taken into the input register goes through the mixing
//   stage, and its hash is loaded into the result register.
// Throughput: one word per cycle unless a last word waits for the result
//   register. The running hash feeds back through the combinational mixing stage (word mix, tail mix and avalanche).
// Stall: while result waits, non-last words keep flowing; a last word holds
//   in the input register until the result register frees, and msg.ready
//   drops only then.
// Reset: running hash cleared to zero, both registers emptied.
`timescale 1ns / 1ps
`include "signed_word_hash_32_assert.svh"

module signed_word_hash_32
(
    input  logic       clk,
    input  logic       rst_n,
    swh_in_if.sink     msg,
    swh_out_if.source  result
);

    // input register
    logic              in_valid_reg;
    logic              in_first_reg;
    logic              in_last_reg;
    swh_pkg::word_t    in_data_reg;
    swh_pkg::nbytes_t  in_nbytes_reg;
    swh_pkg::word_t    in_length_reg;

    // state and result register
    swh_pkg::word_t    running_hash_reg;
    swh_pkg::word_t    running_hash_next;
    logic              empty_reg;
    logic              empty_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    swh_pkg::word_t    hash_reg;

    logic              out_free;
    logic              advance;
    logic              full_word;
    swh_pkg::word_t    base;
    swh_pkg::word_t    mixed;
    swh_pkg::word_t    final_hash;

    assign out_free  = !out_valid_reg || result.ready;
    assign advance   = in_valid_reg && (!in_last_reg || out_free);
    assign msg.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (msg.ready)
        begin
            in_valid_reg <= msg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.ready && msg.valid)
        begin
            in_first_reg  <= msg.first;
            in_last_reg   <= msg.last;
            in_data_reg   <= msg.data_word;
            in_nbytes_reg <= msg.valid_bytes;
            in_length_reg <= msg.total_length;
        end
    end

    // counts of four to seven behave as a full word
    always_comb
    begin
        case (in_nbytes_reg) inside
            [swh_pkg::NBYTES_FULL : {swh_pkg::NBYTES_W{1'b1}}]: full_word = 1'b1;
            default:                                           full_word = 1'b0;
        endcase
    end

    always_comb
    begin
        base       = in_first_reg ? in_length_reg : running_hash_reg;
        empty_next = in_first_reg ? (in_length_reg == '0) : empty_reg;

        if (full_word)
        begin
            mixed = swh_pkg::mix_word(base, in_data_reg);
        end
        else if (in_last_reg)
        begin
            mixed = swh_pkg::mix_tail(base, in_data_reg, in_nbytes_reg[1:0]);
        end
        else
        begin
            mixed = base;
        end

        final_hash        = empty_next ? '0 : swh_pkg::avalanche(mixed);
        running_hash_next = in_last_reg ? final_hash : mixed;
        out_valid_next    = (out_valid_reg && !result.ready) || (advance && in_last_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
            empty_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                running_hash_reg <= running_hash_next;
                empty_reg        <= empty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            hash_reg <= final_hash;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.hash_value = hash_reg;

    `SWH_ASSERT_NOW(a_no_overwrite, in_valid_reg && in_last_reg && out_valid_reg && !result.ready, !advance, "last word advanced over a pending hash")
    `SWH_ASSERT_NEXT(a_last_gives_hash, advance && in_last_reg, out_valid_reg && (hash_reg == running_hash_reg), "last word did not load the result register")
    `SWH_ASSERT_NEXT(a_empty_is_zero, advance && in_last_reg && in_first_reg && (in_length_reg == '0), hash_reg == '0, "empty message hash not zero")
    `SWH_ASSERT_NEXT(a_word_kept, in_valid_reg && !advance, in_valid_reg && $stable(in_data_reg), "held word lost from the input register")

endmodule
